// File: rtl/f2i_pkg.sv
// Package for the float-to-integer converter: operation decode, field widths.
// Used by f2i_core and the top level; depends on nothing.
package f2i_pkg;

    localparam int unsigned ValueW  = 64;
    localparam int unsigned OpW     = 3;
    localparam int unsigned ExpW    = 11;
    localparam int unsigned FracW   = 52;
    localparam logic [ExpW-1:0] ExpMax = 11'h7FF;
    localparam logic [ExpW-1:0] Bias   = 11'd1023;

    typedef logic [OpW-1:0] op_t;

    // Operation codes.
    localparam op_t OP_F32_S32 = 3'd0;
    localparam op_t OP_F32_U32 = 3'd1;
    localparam op_t OP_F32_S64 = 3'd2;
    localparam op_t OP_F32_U64 = 3'd3;
    localparam op_t OP_F64_S32 = 3'd4;
    localparam op_t OP_F64_U32 = 3'd5;
    localparam op_t OP_F64_S64 = 3'd6;
    localparam op_t OP_F64_U64 = 3'd7;

    // Decoded operation passed between the stages.
    typedef struct packed {
        logic is_double;
        logic is_wide;
        logic is_unsigned;
    } op_ctl_t;

    function automatic op_ctl_t decode_op(op_t op);
        op_ctl_t c;
        c.is_double   = op[2];
        c.is_wide     = op[1];
        c.is_unsigned = op[0];
        return c;
    endfunction

endpackage

// File: rtl/f2i_core.sv
// Combinational conversion from an IEEE bit pattern to a saturated integer.
// Depends on f2i_pkg.
module f2i_core (
    input  f2i_pkg::op_ctl_t            ctl,
    input  logic [f2i_pkg::ValueW-1:0]  value,
    output logic [f2i_pkg::ValueW-1:0]  result
);
    import f2i_pkg::*;

    logic            sgn;
    logic [ExpW-1:0] ex;
    logic [FracW-1:0] fr;
    logic [7:0]      e32;
    logic [ExpW-1:0] e;
    logic [6:0]      lim;
    logic [FracW:0]  sig;
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] neg;
    logic [ValueW-1:0] top;

    // Widen a single to double fields; subnormals become zero.
    always_comb begin
        e32 = value[30:23];
        if (ctl.is_double) begin
            sgn = value[63];
            ex  = value[62:52];
            fr  = value[51:0];
        end else begin
            sgn = value[31];
            fr  = {value[22:0], 29'd0};
            if (e32 == 8'd0) begin
                ex = '0;
                fr = '0;
            end else if (e32 == 8'hFF) begin
                ex = ExpMax;
            end else begin
                ex = {3'd0, e32} + 11'd896;
            end
        end
    end

    // Shift the significand into place and apply the special cases.
    always_comb begin
        e   = ex - Bias;
        sig = {1'b1, fr};
        lim = ctl.is_wide ? 7'd64 : 7'd32;
        if (e <= ExpW'(FracW))
            mag = ValueW'(sig >> (6'(FracW) - e[5:0]));
        else
            mag = ValueW'(sig) << (e[5:0] - 6'(FracW));
        neg = sgn ? (~mag + 64'd1) : mag;
        top = ctl.is_wide ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};
        result = '0;
        if (ex == ExpMax && fr != '0) begin
            result = '0;
        end else if (ctl.is_unsigned && sgn) begin
            result = '0;
        end else if (ex < Bias) begin
            result = '0;
        end else if (ctl.is_unsigned) begin
            if (e >= ExpW'(lim))
                result = ctl.is_wide ? '1 : {32'd0, 32'hFFFFFFFF};
            else
                result = ctl.is_wide ? mag : {32'd0, mag[31:0]};
        end else if (e >= ExpW'(lim - 7'd1)) begin
            result = sgn ? top : top - 64'd1;
        end else begin
            result = ctl.is_wide ? neg : {32'd0, neg[31:0]};
        end
    end

endmodule

// File: rtl/float_to_int_saturating_convert.sv
// Top level of the saturating float-to-integer converter.
// Depends on f2i_pkg and f2i_core.
//
//  Channel   Ports                       Dir  Beat
//  input     s_valid s_ready s_op s_value in   one conversion request
//  result    m_valid m_ready m_result    out  one 64-bit integer
//
// One beat is accepted every cycle unless the output stalls. A beat passes the
// input register, conversion logic and result register. A stalled result
// register holds its beat, and a full input register refills only when the output loads.
// Reset (aresetn low, synchronous) clears both valid flags.
module float_to_int_saturating_convert (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [f2i_pkg::OpW-1:0]     s_op,
    input  logic [f2i_pkg::ValueW-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [f2i_pkg::ValueW-1:0]  m_result
);
    import f2i_pkg::*;

    logic              in_valid_reg;
    op_ctl_t           in_ctl_reg;
    logic [ValueW-1:0] in_value_reg;
    logic              out_valid_reg;
    logic [ValueW-1:0] out_result_reg;
    logic [ValueW-1:0] conv_next;
    logic              out_load;

    // The result register loads when empty or being drained.
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;

    f2i_core u_core (
        .ctl    (in_ctl_reg),
        .value  (in_value_reg),
        .result (conv_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_ctl_reg   <= decode_op(s_op);
            in_value_reg <= s_value;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            out_result_reg <= conv_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

    // A full pipeline with a stalled output refuses new beats.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are held");

    // A held result stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result)))
        else $error("stalled result changed");

    // An accepted beat reaches the input stage.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted beat lost");

endmodule

// File: test/float_to_int_saturating_convert_test.sv
// Testbench for the saturating float-to-integer converter: directed and random beats.
// Depends on f2i_pkg and the float_to_int_saturating_convert top level.
`timescale 1ns / 1ps

module float_to_int_saturating_convert_test;
    import f2i_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    op_t         s_op = OP_F32_S32;
    logic [63:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result;

    logic [63:0] pending_ints[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          send_idles = 1'b1;
    bit          recv_idles = 1'b1;
    bit          recv_hold = 1'b0;

    localparam int CycleLimit = 200000;

    float_to_int_saturating_convert i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result)
    );

    always #1 aclk = ~aclk;

    // Exact truncating, saturating conversion on the double-precision fields.
    function automatic logic [63:0] truncate_saturate(op_t op, logic [63:0] v);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] fr;
        logic [7:0]  e32;
        int          width;
        int          e;
        bit          is_signed;
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] top;
        if (op[2] == 1'b0) begin
            sgn = v[31];
            e32 = v[30:23];
            fr  = {v[22:0], 29'd0};
            if (e32 == 8'd0) begin
                ex = '0;
                fr = '0;
            end else if (e32 == 8'hFF) begin
                ex = ExpMax;
            end else begin
                ex = 11'(e32) + 11'd896;
            end
        end else begin
            sgn = v[63];
            ex  = v[62:52];
            fr  = v[51:0];
        end
        width = op[1] ? 64 : 32;
        is_signed = !op[0];
        mask = (width == 64) ? '1 : 64'hFFFF_FFFF;
        if (ex == ExpMax && fr != 0) return '0;
        if (!is_signed && sgn) return '0;
        if (ex < Bias) return '0;
        e = int'(ex) - 1023;
        if (!is_signed) begin
            if (e >= width) return mask;
        end else if (e >= width - 1) begin
            top = 64'd1 << (width - 1);
            return (sgn ? top : top - 1) & mask;
        end
        mag = {11'd0, 1'b1, fr};
        if (e <= 52) mag = mag >> (52 - e);
        else mag = mag << (e - 52);
        if (sgn) mag = -mag;
        return mag & mask;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // Send one beat and hold it until accepted; idles at random first.
    task automatic send_beat(op_t op, logic [63:0] v);
        while (send_idles && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= v;
        pending_ints.push_back(truncate_saturate(op, v));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random pattern biased toward the interesting exponent window.
    function automatic logic [63:0] rand_pattern(op_t op);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: if (op[2]) v[62:52] = 11'(1023 + $urandom_range(70) - 5);
               else v[30:23] = 8'(127 + $urandom_range(70) - 5);
            2: if (op[2]) v[62:52] = $urandom_range(1) ? ExpMax : 11'd0;
               else v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: if (op[2]) v[62:52] = 11'(1023 + $urandom_range(2) + 30 +
                                             32 * $urandom_range(1) - 1);
                     else v[30:23] = 8'(127 + $urandom_range(2) + 30 +
                                        32 * $urandom_range(1) - 1);
        endcase
        return v;
    endfunction

    // Receiver: random stalls, or a long hold when asked.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn || recv_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_idles && $urandom_range(99) < 10);
        end
    end

    // Check each accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_ints.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_result));
            end else begin
                if (m_result !== pending_ints[0]) begin
                    report_mismatch($sformatf("result %h, expected %h",
                                              m_result, pending_ints[0]));
                end
                void'(pending_ints.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count >= CycleLimit) begin
            $display("float_to_int_saturating_convert_test: errors");
            $finish;
        end
    end

    // Extremes, zeros, NaN, infinity and the exact saturation thresholds.
    task automatic test_directed();
        logic [63:0] singles[] = '{64'h0, 64'h8000_0000, 64'h7FC0_0000, 64'hFFC0_0001,
                                   64'h7F80_0000, 64'hFF80_0000, 64'h4F00_0000,
                                   64'hCF00_0000, 64'h4F80_0000, 64'h5F00_0000,
                                   64'hDF00_0000, 64'h5F80_0000, 64'hBF7F_FFFF,
                                   64'h0000_0001, 64'h3FC0_0000, 64'hFFFF_FFFF_4EFF_FFFF};
        logic [63:0] doubles[] = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                                   64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                                   64'h41E0_0000_0000_0000, 64'hC1E0_0000_0000_0000,
                                   64'h41DF_FFFF_FFC0_0000, 64'h41F0_0000_0000_0000,
                                   64'h42E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
                                   64'h43E0_0000_0000_0000, 64'h43F0_0000_0000_0000,
                                   64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
        for (int o = 0; o < 8; o++) begin
            if (o < 4) foreach (singles[i]) send_beat(op_t'(o), singles[i]);
            else foreach (doubles[i]) send_beat(op_t'(o), doubles[i]);
        end
    endtask

    // Random beats, part of them with no idling on either side.
    task automatic test_random(int count, bit idles);
        op_t op;
        send_idles = idles;
        recv_idles = idles;
        repeat (count) begin
            op = op_t'($urandom_range(7));
            send_beat(op, rand_pattern(op));
        end
        send_idles = 1'b1;
        recv_idles = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        op_t op;
        fork
            begin
                recv_hold = 1'b1;
                repeat (40) @(posedge aclk);
                recv_hold = 1'b0;
            end
            repeat (30) begin
                op = op_t'($urandom_range(7));
                send_beat(op, rand_pattern(op));
            end
        join
    endtask

    initial begin
        int wait_cycles;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300, 1'b1);
        test_backpressure();
        test_random(200, 1'b0);
        stop_sending();
        wait_cycles = 0;
        while (pending_ints.size() != 0 && wait_cycles < 10000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_ints.size() == 0) begin
            $display("float_to_int_saturating_convert_test: clean");
        end else begin
            $display("float_to_int_saturating_convert_test: errors");
        end
        $finish;
    end

endmodule
